[src/idl_pkg.sv]
`default_nettype none
package idl_pkg;

    typedef enum logic [2:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_BACK   = 3'd2,
        REQ_POP_HEAD   = 3'd3,
        REQ_INSERT     = 3'd4,
        REQ_GET        = 3'd5,
        REQ_SET        = 3'd6,
        REQ_REMOVE     = 3'd7
    } req_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BOUNDS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_WALK_ISSUE,
        S_WALK_WAIT,
        S_ACT_ISSUE,
        S_ACT_WAIT,
        S_LINK_A,
        S_LINK_B,
        S_FREE_RD,
        S_FREE_WAIT,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

[src/idl_node_ram.sv]
`default_nettype none
// Node pool: word, forward and back link per node. Three writes, one read.
module idl_node_ram #(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = $clog2(DEPTH),
    parameter int LW         = $clog2(DEPTH + 1)
) (
    input  wire logic                  clk,
    input  wire logic [AW-1:0]         rd_addr,
    output logic      [DATA_WIDTH-1:0] rd_word,
    output logic      [LW-1:0]         rd_next,
    output logic      [LW-1:0]         rd_prev,
    input  wire logic                  we_word,
    input  wire logic [AW-1:0]         word_addr,
    input  wire logic [DATA_WIDTH-1:0] word_data,
    input  wire logic                  we_next,
    input  wire logic [AW-1:0]         next_addr,
    input  wire logic [LW-1:0]         next_data,
    input  wire logic                  we_prev,
    input  wire logic [AW-1:0]         prev_addr,
    input  wire logic [LW-1:0]         prev_data
);

    logic [DATA_WIDTH-1:0] word_mem [DEPTH];
    logic [LW-1:0]         next_mem [DEPTH];
    logic [LW-1:0]         prev_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we_word)
        begin
            word_mem[word_addr] <= word_data;
        end
        rd_word <= word_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we_next)
        begin
            next_mem[next_addr] <= next_data;
        end
        rd_next <= next_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we_prev)
        begin
            prev_mem[prev_addr] <= prev_data;
        end
        rd_prev <= prev_mem[rd_addr];
    end

endmodule
`default_nettype wire

[src/idl_free_stack.sv]
`default_nettype none
// Free node stack. Reset state (every node on the stack, entry i holds i) is
// given by a low mark: slots below low_reg were never written and read as
// their own index.
module idl_free_stack #(
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [AW-1:0] rd_data,
    input  wire logic          we,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [AW-1:0] wr_data
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0] mem [DEPTH];
    logic [CW-1:0] low_reg;
    logic [CW-1:0] low_next;
    logic [AW-1:0] mem_q;
    logic          raw_q;
    logic [AW-1:0] addr_q;

    // Pushes go to the slot at the current top, and the top only climbs by
    // pushing, so every slot from the lowest write up to the top is written.
    always_comb
    begin
        low_next = low_reg;
        if (we && (CW'({1'b0, wr_addr}) < low_reg))
        begin
            low_next = CW'({1'b0, wr_addr});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg <= CW'(DEPTH);
        end
        else
        begin
            low_reg <= low_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_q  <= mem[rd_addr];
        raw_q  <= (CW'({1'b0, rd_addr}) < low_reg);
        addr_q <= rd_addr;
    end

    assign rd_data = raw_q ? addr_q : mem_q;

endmodule
`default_nettype wire

[src/indexed_deque_list_core.sv]
`default_nettype none
// indexed_deque_list_core: bounded list of data words kept as a doubly linked
// pool of DEPTH nodes.
//
// Request channel: drive req_type, position, write_value and raise start
// while busy is low; the request is taken at that clock edge and busy rises
// the cycle after. Requests: push back/front, pop back/front, insert before
// a position, get, set and remove at a position.
//
// Result channel: done pulses for one cycle with status, read_value and
// length. The receiver cannot stall; it must take the result in that cycle.
// busy drops at the edge that ends the done cycle; the next request is taken
// at the following edge at the earliest.
//
// Sequence: a rejected request goes from the check straight to the result.
// Other requests, appends apart, walk W link hops from the nearer end of the
// list (W <= DEPTH/2), each hop one registered read of the node RAM, then
// read the target node; inserts then pop a free node and write the links,
// removes unlink the target. No new request is taken until the result of
// the last one is out.
//
// Reset: asynchronous, active low. The list comes up empty with every node
// free; no clearing pass is needed.
module indexed_deque_list_core #(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  req_type,
    input  wire logic [5:0]  position,
    input  wire logic [31:0] write_value,
    output logic             done,
    output logic [1:0]       status,
    output logic [31:0]      read_value,
    output logic [5:0]       length
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam logic [LW-1:0] NIL = LW'(DEPTH);

    // Request latches
    idl_pkg::req_t         req_reg;
    logic [LW-1:0]         pos_reg;
    logic                  pos_ovf_reg;
    logic [DATA_WIDTH-1:0] wv_reg;

    // List state
    logic [LW-1:0] head_reg, head_next;
    logic [LW-1:0] tail_reg, tail_next;
    logic [LW-1:0] count_reg, count_next;
    logic [LW-1:0] free_top_reg, free_top_next;

    // Sequencer
    idl_pkg::state_t state_reg, state_next;
    logic [LW-1:0]   cur_reg, cur_next;     // node being walked / target
    logic [LW-1:0]   steps_reg, steps_next; // hops left
    logic            dir_reg, dir_next;     // 1: walk backward
    logic [LW-1:0]   nn_reg, nn_next;       // freshly allocated node
    logic [LW-1:0]   lp_reg, lp_next;       // target's prev link
    logic [LW-1:0]   lx_reg, lx_next;       // target's next link
    logic [1:0]      st_reg, st_next;
    logic [31:0]     rd_reg, rd_next;

    // RAM ports
    logic [AW-1:0]         ram_addr;
    logic [DATA_WIDTH-1:0] ram_word;
    logic [LW-1:0]         ram_nlink, ram_plink;
    logic                  we_word, we_nlink, we_plink;
    logic [AW-1:0]         word_addr, nlink_addr, plink_addr;
    logic [DATA_WIDTH-1:0] word_data;
    logic [LW-1:0]         nlink_data, plink_data;

    logic [AW-1:0] fs_rd_addr, fs_rd_data, fs_wr_addr, fs_wr_data;
    logic          fs_we;

    // Effective position of the request (end ops map to 0, count or count - 1)
    logic [LW-1:0] eff_pos;
    logic          eff_ovf;   // position port out of range, positional ops only
    logic          is_ins;

    idl_node_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk       (clk),
        .rd_addr   (ram_addr),
        .rd_word   (ram_word),
        .rd_next   (ram_nlink),
        .rd_prev   (ram_plink),
        .we_word   (we_word),
        .word_addr (word_addr),
        .word_data (word_data),
        .we_next   (we_nlink),
        .next_addr (nlink_addr),
        .next_data (nlink_data),
        .we_prev   (we_plink),
        .prev_addr (plink_addr),
        .prev_data (plink_data)
    );

    idl_free_stack #(
        .DEPTH (DEPTH)
    ) u_free (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (fs_rd_addr),
        .rd_data (fs_rd_data),
        .we      (fs_we),
        .wr_addr (fs_wr_addr),
        .wr_data (fs_wr_data)
    );

    always_comb
    begin
        case (req_reg)
            idl_pkg::REQ_PUSH_BACK:  eff_pos = count_reg;
            idl_pkg::REQ_PUSH_FRONT: eff_pos = '0;
            idl_pkg::REQ_POP_BACK:   eff_pos = count_reg - LW'(1);
            idl_pkg::REQ_POP_HEAD:   eff_pos = '0;
            default:                 eff_pos = pos_reg;
        endcase
        eff_ovf = pos_ovf_reg && ((req_reg == idl_pkg::REQ_INSERT)
              || (req_reg == idl_pkg::REQ_GET) || (req_reg == idl_pkg::REQ_SET)
              || (req_reg == idl_pkg::REQ_REMOVE));
        is_ins = (req_reg == idl_pkg::REQ_PUSH_BACK) || (req_reg == idl_pkg::REQ_PUSH_FRONT)
              || (req_reg == idl_pkg::REQ_INSERT);
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg     <= idl_pkg::req_t'(req_type);
            pos_reg     <= LW'(position);
            pos_ovf_reg <= (32'(position) > DEPTH);
            wv_reg      <= DATA_WIDTH'(write_value);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            idl_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = idl_pkg::S_CHECK;
                end
            end
            idl_pkg::S_CHECK:
            begin
                if (st_next != 2'(idl_pkg::ST_OK))
                begin
                    state_next = idl_pkg::S_DONE;
                end
                else if (is_ins && eff_pos == count_reg)
                begin
                    state_next = idl_pkg::S_FREE_RD;
                end
                else
                begin
                    state_next = idl_pkg::S_WALK_ISSUE;
                end
            end
            idl_pkg::S_WALK_ISSUE:
            begin
                state_next = (steps_reg == '0) ? idl_pkg::S_ACT_ISSUE : idl_pkg::S_WALK_WAIT;
            end
            idl_pkg::S_WALK_WAIT:  state_next = idl_pkg::S_WALK_ISSUE;
            idl_pkg::S_ACT_ISSUE:  state_next = idl_pkg::S_ACT_WAIT;
            idl_pkg::S_ACT_WAIT:
            begin
                if (req_reg == idl_pkg::REQ_GET || req_reg == idl_pkg::REQ_SET)
                begin
                    state_next = idl_pkg::S_DONE;
                end
                else if (is_ins)
                begin
                    state_next = idl_pkg::S_FREE_RD;
                end
                else
                begin
                    state_next = idl_pkg::S_LINK_A;
                end
            end
            idl_pkg::S_FREE_RD:    state_next = idl_pkg::S_FREE_WAIT;
            idl_pkg::S_FREE_WAIT:  state_next = idl_pkg::S_LINK_A;
            idl_pkg::S_LINK_A:     state_next = idl_pkg::S_LINK_B;
            idl_pkg::S_LINK_B:     state_next = idl_pkg::S_DONE;
            idl_pkg::S_DONE:       state_next = idl_pkg::S_IDLE;
            default:               state_next = idl_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        free_top_next = free_top_reg;
        cur_next      = cur_reg;
        steps_next    = steps_reg;
        dir_next      = dir_reg;
        nn_next       = nn_reg;
        lp_next       = lp_reg;
        lx_next       = lx_reg;
        st_next       = st_reg;
        rd_next       = rd_reg;
        ram_addr      = cur_reg[AW-1:0];
        we_word       = 1'b0;
        we_nlink      = 1'b0;
        we_plink      = 1'b0;
        word_addr     = cur_reg[AW-1:0];
        word_data     = wv_reg;
        nlink_addr    = cur_reg[AW-1:0];
        nlink_data    = NIL;
        plink_addr    = cur_reg[AW-1:0];
        plink_data    = NIL;
        fs_rd_addr    = AW'(free_top_reg - LW'(1));
        fs_we         = 1'b0;
        fs_wr_addr    = free_top_reg[AW-1:0];
        fs_wr_data    = cur_reg[AW-1:0];

        case (state_reg)
            idl_pkg::S_IDLE:
            begin
                st_next = 2'(idl_pkg::ST_OK);
                rd_next = '0;
            end
            idl_pkg::S_CHECK:
            begin
                st_next = 2'(idl_pkg::ST_OK);
                if (is_ins)
                begin
                    if (eff_ovf || eff_pos > count_reg)
                        st_next = 2'(idl_pkg::ST_BOUNDS);
                    else if (free_top_reg == '0)
                        st_next = 2'(idl_pkg::ST_FULL);
                end
                else if (req_reg == idl_pkg::REQ_SET)
                begin
                    if (eff_ovf || eff_pos >= count_reg)
                        st_next = 2'(idl_pkg::ST_BOUNDS);
                end
                else if (count_reg == '0)
                begin
                    st_next = 2'(idl_pkg::ST_EMPTY);
                end
                else if (eff_ovf || eff_pos >= count_reg)
                begin
                    st_next = 2'(idl_pkg::ST_BOUNDS);
                end
                // Walk from the nearer end
                if (count_reg - eff_pos < eff_pos)
                begin
                    dir_next   = 1'b1;
                    cur_next   = tail_reg;
                    steps_next = count_reg - LW'(1) - eff_pos;
                end
                else
                begin
                    dir_next   = 1'b0;
                    cur_next   = head_reg;
                    steps_next = eff_pos;
                end
            end
            idl_pkg::S_WALK_ISSUE:
            begin
                ram_addr = cur_reg[AW-1:0];
            end
            idl_pkg::S_WALK_WAIT:
            begin
                cur_next   = dir_reg ? ram_plink : ram_nlink;
                steps_next = steps_reg - LW'(1);
            end
            idl_pkg::S_ACT_ISSUE:
            begin
                ram_addr = cur_reg[AW-1:0];
            end
            idl_pkg::S_ACT_WAIT:
            begin
                lp_next = ram_plink;
                lx_next = ram_nlink;
                if (req_reg == idl_pkg::REQ_SET)
                begin
                    we_word = 1'b1;
                end
                else if (!is_ins)
                begin
                    rd_next = 32'(ram_word);
                end
            end
            idl_pkg::S_FREE_RD:
            begin
                fs_rd_addr    = AW'(free_top_reg - LW'(1));
                free_top_next = free_top_reg - LW'(1);
            end
            idl_pkg::S_FREE_WAIT:
            begin
                nn_next = LW'(fs_rd_data);
            end
            idl_pkg::S_LINK_A:
            begin
                if (is_ins)
                begin
                    // New node: word and both links
                    we_word   = 1'b1;
                    word_addr = nn_reg[AW-1:0];
                    we_nlink  = 1'b1;
                    we_plink  = 1'b1;
                    nlink_addr = nn_reg[AW-1:0];
                    plink_addr = nn_reg[AW-1:0];
                    if (eff_pos == count_reg)
                    begin
                        nlink_data = NIL;
                        plink_data = tail_reg;
                    end
                    else
                    begin
                        nlink_data = cur_reg;
                        plink_data = lp_reg;
                    end
                end
                else
                begin
                    // Unlink: predecessor forward, successor back
                    if (lp_reg == NIL)
                        head_next = lx_reg;
                    else
                    begin
                        we_nlink   = 1'b1;
                        nlink_addr = lp_reg[AW-1:0];
                        nlink_data = lx_reg;
                    end
                    if (lx_reg == NIL)
                        tail_next = lp_reg;
                    else
                    begin
                        we_plink   = 1'b1;
                        plink_addr = lx_reg[AW-1:0];
                        plink_data = lp_reg;
                    end
                    if (free_top_reg < NIL)
                    begin
                        fs_we         = 1'b1;
                        fs_wr_addr    = free_top_reg[AW-1:0];
                        fs_wr_data    = cur_reg[AW-1:0];
                        free_top_next = free_top_reg + LW'(1);
                    end
                    count_next = count_reg - LW'(1);
                end
            end
            idl_pkg::S_LINK_B:
            begin
                if (is_ins)
                begin
                    if (eff_pos == count_reg)
                    begin
                        if (tail_reg == NIL)
                            head_next = nn_reg;
                        else
                        begin
                            we_nlink   = 1'b1;
                            nlink_addr = tail_reg[AW-1:0];
                            nlink_data = nn_reg;
                        end
                        tail_next = nn_reg;
                    end
                    else
                    begin
                        we_plink   = 1'b1;
                        plink_addr = cur_reg[AW-1:0];
                        plink_data = nn_reg;
                        if (lp_reg == NIL)
                            head_next = nn_reg;
                        else
                        begin
                            we_nlink   = 1'b1;
                            nlink_addr = lp_reg[AW-1:0];
                            nlink_data = nn_reg;
                        end
                    end
                    count_next = count_reg + LW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= idl_pkg::S_IDLE;
            head_reg     <= NIL;
            tail_reg     <= NIL;
            count_reg    <= '0;
            free_top_reg <= NIL;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            free_top_reg <= free_top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        steps_reg <= steps_next;
        dir_reg   <= dir_next;
        nn_reg    <= nn_next;
        lp_reg    <= lp_next;
        lx_reg    <= lx_next;
        st_reg    <= st_next;
        rd_reg    <= rd_next;
    end

    // Outputs
    always_comb
    begin
        busy       = (state_reg != idl_pkg::S_IDLE);
        done       = (state_reg == idl_pkg::S_DONE);
        status     = st_reg;
        read_value = (st_reg == 2'(idl_pkg::ST_OK)) ? rd_reg : '0;
        length     = 6'(count_reg);
    end

endmodule
`default_nettype wire

[src/idl_checker.sv]
`default_nettype none
module idl_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [1:0]  status,
    input wire logic [31:0] read_value,
    input wire logic [5:0]  length
);

    // A result only ends a request in flight.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    // Accepted request raises busy.
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accept did not raise busy");

    // Failed request returns zero data.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != 2'(idl_pkg::ST_OK)) |-> (read_value == 32'd0))
        else $error("nonzero data on error");

    // Length stays put while idle.
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !$past(busy)) |-> $stable(length))
        else $error("length moved while idle");

endmodule

bind indexed_deque_list_core idl_checker u_idl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .read_value (read_value),
    .length     (length)
);
`default_nettype wire
